### rtl/core/rbh_pkg.sv
// Shared constants for the range binned histogram: register map, field widths, defaults.
package rbh_pkg;

    // Parameter defaults
    localparam int DEF_MAX_RECORDS = 512;
    localparam int DEF_NUM_MAPS    = 4;
    localparam int DEF_ANGLE_BINS  = 3;
    localparam int DEF_SEC_BINS    = 6;

    // Field widths
    localparam int DIST_W      = 16;
    localparam int STEP_W      = 14;
    localparam int ANGLE_W     = 15;
    localparam int ASTEP_W     = 13;
    localparam int INDEX_OUT_W = 2;
    localparam int COUNT_OUT_W = 10;

    // Readout shape
    localparam int NREPORT  = 6;
    localparam int ROWS_MAX = 12;
    localparam int ROW_W    = $clog2(ROWS_MAX);

    // Edge arithmetic: base + 16 * step fits in 20 bits for the full parameter range
    localparam int EDGE_W = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEC_BASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEC_STEP   = 3'd5;

    // Register reset values
    localparam logic [DIST_W-1:0]  RST_DIST_BASE  = 16'd2300;
    localparam logic [STEP_W-1:0]  RST_DIST_STEP  = 14'd100;
    localparam logic [ANGLE_W-1:0] RST_ANGLE_BASE = 15'd15000;
    localparam logic [ASTEP_W-1:0] RST_ANGLE_STEP = 13'd1000;
    localparam logic [DIST_W-1:0]  RST_SEC_BASE   = 16'd500;
    localparam logic [STEP_W-1:0]  RST_SEC_STEP   = 14'd250;

endpackage

### rtl/core/rbh_ram.sv
// Generic simple dual-port RAM, registered read, old data on read-during-write.
module rbh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/rbh_decode.sv
// Record decoder: angle bin, secondary bin and the set of primary maps hit.
module rbh_decode
    import rbh_pkg::*;
#(
    parameter int NUM_MAPS   = DEF_NUM_MAPS,
    parameter int ANGLE_BINS = DEF_ANGLE_BINS,
    parameter int SEC_BINS   = DEF_SEC_BINS,
    parameter int AW         = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1,
    parameter int SW         = (SEC_BINS > 1) ? $clog2(SEC_BINS) : 1
) (
    input  logic [DIST_W-1:0]   dist_base,
    input  logic [STEP_W-1:0]   dist_step,
    input  logic [ANGLE_W-1:0]  angle_base,
    input  logic [ASTEP_W-1:0]  angle_step,
    input  logic [DIST_W-1:0]   sec_base,
    input  logic [STEP_W-1:0]   sec_step,
    input  logic                has_record,
    input  logic [DIST_W-1:0]   primary_dist,
    input  logic [DIST_W-1:0]   secondary_dist,
    input  logic [ANGLE_W-1:0]  bond_angle,
    output logic [AW-1:0]       abin,
    output logic [SW-1:0]       sbin,
    output logic [NUM_MAPS-1:0] map_mask,
    output logic                hit
);

    logic [ANGLE_BINS-1:0] a_in;
    logic [SEC_BINS-1:0]   s_in;
    logic [EDGE_W-1:0]     lo, hi;

    always_comb begin
        a_in     = '0;
        s_in     = '0;
        map_mask = '0;
        abin     = '0;
        sbin     = '0;
        lo       = '0;
        hi       = '0;

        // lowest matching angle bin wins
        for (int a = ANGLE_BINS - 1; a >= 0; a--) begin
            lo = EDGE_W'(angle_base) + EDGE_W'(angle_step) * EDGE_W'(a);
            hi = EDGE_W'(angle_base) + EDGE_W'(angle_step) * EDGE_W'(a + 1);
            a_in[a] = (EDGE_W'(bond_angle) >= lo) && (EDGE_W'(bond_angle) <= hi);
            if (a_in[a]) begin
                abin = AW'(a);
            end
        end

        // bin 0 closed, the rest open below
        for (int k = SEC_BINS - 1; k >= 0; k--) begin
            lo = EDGE_W'(sec_base) + EDGE_W'(sec_step) * EDGE_W'(k);
            hi = EDGE_W'(sec_base) + EDGE_W'(sec_step) * EDGE_W'(k + 1);
            if (k == 0) begin
                s_in[k] = (EDGE_W'(secondary_dist) >= lo) && (EDGE_W'(secondary_dist) <= hi);
            end else begin
                s_in[k] = (EDGE_W'(secondary_dist) > lo) && (EDGE_W'(secondary_dist) <= hi);
            end
            if (s_in[k]) begin
                sbin = SW'(k);
            end
        end

        // every closed map range holding the distance
        for (int m = 0; m < NUM_MAPS; m++) begin
            lo = EDGE_W'(dist_base) + EDGE_W'(dist_step) * EDGE_W'(m);
            hi = EDGE_W'(dist_base) + EDGE_W'(dist_step) * EDGE_W'(m + 1);
            map_mask[m] = (EDGE_W'(primary_dist) >= lo) && (EDGE_W'(primary_dist) <= hi);
        end

        hit = has_record && (|a_in) && (|s_in) && (|map_mask);
    end

endmodule

### rtl/core/range_binned_histogram.sv
// Range binned histogram top level: counter store, update pipeline, snapshot readout.
// Counting: one word per cycle while ready; counts are written the cycle after accept.
// Readout: on an end marker, flush, issue and load run before the first row is offered,
//   then issue and load per row after each take; input held off until the last row goes.
// Reset (aresetn low, synchronous): registers to defaults, all counters read as zero
//   through per-entry valid bits; no clearing pass. Readout clears the same way.
module range_binned_histogram
    import rbh_pkg::*;
#(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS,
    parameter int NUM_MAPS    = DEF_NUM_MAPS,
    parameter int ANGLE_BINS  = DEF_ANGLE_BINS,
    parameter int SEC_BINS    = DEF_SEC_BINS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_has_record,
    input  logic [DIST_W-1:0]      s_primary_dist,
    input  logic [DIST_W-1:0]      s_secondary_dist,
    input  logic [ANGLE_W-1:0]     s_bond_angle,
    input  logic                   s_end_of_snapshot,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [INDEX_OUT_W-1:0] m_map_index,
    output logic [INDEX_OUT_W-1:0] m_angle_index,
    output logic [COUNT_OUT_W-1:0] m_bin_count_0,
    output logic [COUNT_OUT_W-1:0] m_bin_count_1,
    output logic [COUNT_OUT_W-1:0] m_bin_count_2,
    output logic [COUNT_OUT_W-1:0] m_bin_count_3,
    output logic [COUNT_OUT_W-1:0] m_bin_count_4,
    output logic [COUNT_OUT_W-1:0] m_bin_count_5,
    output logic                   m_last_row
);

    // ------------------------------------------------------------------
    // Sizes. One RAM word per angle bin holds every map's secondary bins,
    // so a record that hits several maps is a single read-modify-write.
    // ------------------------------------------------------------------
    localparam int CW     = $clog2(MAX_RECORDS + 1);
    localparam int AW     = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
    localparam int MW     = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
    localparam int SW     = (SEC_BINS > 1) ? $clog2(SEC_BINS) : 1;
    localparam int WORD_W = NUM_MAPS * SEC_BINS * CW;
    localparam int NROWS  = (NUM_MAPS * ANGLE_BINS > ROWS_MAX) ? ROWS_MAX
                                                               : NUM_MAPS * ANGLE_BINS;

    typedef logic [NUM_MAPS-1:0][SEC_BINS-1:0][CW-1:0] row_word_t;

    // Sequencer states
    localparam logic [2:0] ST_RUN   = 3'd0;  // counting records
    localparam logic [2:0] ST_FLUSH = 3'd1;  // last write of the snapshot lands
    localparam logic [2:0] ST_ISSUE = 3'd2;  // read word of current angle bin
    localparam logic [2:0] ST_LOAD  = 3'd3;  // capture row into output regs
    localparam logic [2:0] ST_WAIT  = 3'd4;  // row offered downstream

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIST_W-1:0]  dist_base_reg;
    logic [STEP_W-1:0]  dist_step_reg;
    logic [ANGLE_W-1:0] angle_base_reg;
    logic [ASTEP_W-1:0] angle_step_reg;
    logic [DIST_W-1:0]  sec_base_reg;
    logic [STEP_W-1:0]  sec_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_base_reg  <= RST_DIST_BASE;
            dist_step_reg  <= RST_DIST_STEP;
            angle_base_reg <= RST_ANGLE_BASE;
            angle_step_reg <= RST_ANGLE_STEP;
            sec_base_reg   <= RST_SEC_BASE;
            sec_step_reg   <= RST_SEC_STEP;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIST_BASE:  dist_base_reg  <= cfg_wdata[DIST_W-1:0];
                REG_DIST_STEP:  dist_step_reg  <= cfg_wdata[STEP_W-1:0];
                REG_ANGLE_BASE: angle_base_reg <= cfg_wdata[ANGLE_W-1:0];
                REG_ANGLE_STEP: angle_step_reg <= cfg_wdata[ASTEP_W-1:0];
                REG_SEC_BASE:   sec_base_reg   <= cfg_wdata[DIST_W-1:0];
                REG_SEC_STEP:   sec_step_reg   <= cfg_wdata[STEP_W-1:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decode the incoming word straight from the ports; its angle bin is
    // the RAM read address in the accept cycle.
    // ------------------------------------------------------------------
    logic [AW-1:0]       dec_abin;
    logic [SW-1:0]       dec_sbin;
    logic [NUM_MAPS-1:0] dec_mask;
    logic                dec_hit;

    rbh_decode #(
        .NUM_MAPS   (NUM_MAPS),
        .ANGLE_BINS (ANGLE_BINS),
        .SEC_BINS   (SEC_BINS),
        .AW         (AW),
        .SW         (SW)
    ) u_decode (
        .dist_base      (dist_base_reg),
        .dist_step      (dist_step_reg),
        .angle_base     (angle_base_reg),
        .angle_step     (angle_step_reg),
        .sec_base       (sec_base_reg),
        .sec_step       (sec_step_reg),
        .has_record     (s_has_record),
        .primary_dist   (s_primary_dist),
        .secondary_dist (s_secondary_dist),
        .bond_angle     (s_bond_angle),
        .abin           (dec_abin),
        .sbin           (dec_sbin),
        .map_mask       (dec_mask),
        .hit            (dec_hit)
    );

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [2:0]            state_reg, state_next;
    logic [MW-1:0]         m_cnt_reg, m_cnt_next;
    logic [AW-1:0]         a_cnt_reg, a_cnt_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [ANGLE_BINS-1:0] ent_valid_reg, ent_valid_next;

    // update pipeline
    logic                  p1_hit_reg;
    logic [AW-1:0]         p1_abin_reg;
    logic [SW-1:0]         p1_sbin_reg;
    logic [NUM_MAPS-1:0]   p1_mask_reg;
    logic                  rd_valid_reg;   // entry was valid when read
    logic                  wb_valid_reg;   // last cycle's write, for forwarding
    logic [AW-1:0]         wb_addr_reg;
    row_word_t             wb_data_reg;

    // output regs
    logic                   m_valid_reg, m_valid_next;
    logic [INDEX_OUT_W-1:0] map_idx_reg, angle_idx_reg;
    logic [COUNT_OUT_W-1:0] count_reg [NREPORT];
    logic                   last_reg;

    logic                   s_accept;
    logic                   row_load;
    logic                   is_last;

    assign s_ready  = (state_reg == ST_RUN);
    assign s_accept = s_valid && s_ready;
    assign is_last  = (row_reg == ROW_W'(NROWS - 1));

    // ------------------------------------------------------------------
    // Counter store
    // ------------------------------------------------------------------
    logic [AW-1:0] ram_raddr;
    row_word_t     ram_rdata;
    row_word_t     base_word, upd_word;
    logic          fwd;

    assign ram_raddr = (state_reg == ST_RUN) ? dec_abin : a_cnt_reg;

    rbh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ANGLE_BINS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (p1_hit_reg),
        .waddr (p1_abin_reg),
        .wdata (upd_word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Back-to-back records on the same angle bin: the RAM returned the
    // word from before last cycle's write, so take the written copy.
    assign fwd = wb_valid_reg && (wb_addr_reg == p1_abin_reg);

    always_comb begin
        if (fwd) begin
            base_word = wb_data_reg;
        end else if (rd_valid_reg) begin
            base_word = ram_rdata;
        end else begin
            base_word = '0;
        end
        upd_word = base_word;
        for (int m = 0; m < NUM_MAPS; m++) begin
            if (p1_mask_reg[m] && (base_word[m][p1_sbin_reg] < CW'(MAX_RECORDS))) begin
                upd_word[m][p1_sbin_reg] = base_word[m][p1_sbin_reg] + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        p1_abin_reg  <= dec_abin;
        p1_sbin_reg  <= dec_sbin;
        p1_mask_reg  <= dec_mask;
        rd_valid_reg <= ent_valid_reg[ram_raddr];
        wb_addr_reg  <= p1_abin_reg;
        wb_data_reg  <= upd_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_hit_reg   <= 1'b0;
            wb_valid_reg <= 1'b0;
        end else begin
            p1_hit_reg   <= s_accept && dec_hit;
            wb_valid_reg <= p1_hit_reg;
        end
    end

    // ------------------------------------------------------------------
    // Readout row slicing
    // ------------------------------------------------------------------
    row_word_t              row_word;
    logic [COUNT_OUT_W-1:0] row_counts [NREPORT];

    assign row_word = rd_valid_reg ? ram_rdata : '0;

    for (genvar j = 0; j < NREPORT; j++) begin : g_report
        if (j < SEC_BINS) begin : g_bin
            assign row_counts[j] = COUNT_OUT_W'(row_word[m_cnt_reg][j]);
        end else begin : g_none
            assign row_counts[j] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        m_cnt_next     = m_cnt_reg;
        a_cnt_next     = a_cnt_reg;
        row_next       = row_reg;
        ent_valid_next = ent_valid_reg;
        m_valid_next   = m_valid_reg;
        row_load       = 1'b0;

        if (p1_hit_reg) begin
            ent_valid_next[p1_abin_reg] = 1'b1;
        end

        case (state_reg)
            ST_RUN: begin
                if (s_accept && s_end_of_snapshot) begin
                    state_next = ST_FLUSH;
                    m_cnt_next = '0;
                    a_cnt_next = '0;
                    row_next   = '0;
                end
            end
            ST_FLUSH: begin
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                row_load     = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_WAIT;
            end
            ST_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (is_last) begin
                        ent_valid_next = '0;   // snapshot cleared
                        state_next     = ST_RUN;
                    end else begin
                        row_next   = row_reg + ROW_W'(1);
                        state_next = ST_ISSUE;
                        if (a_cnt_reg == AW'(ANGLE_BINS - 1)) begin
                            a_cnt_next = '0;
                            m_cnt_next = m_cnt_reg + MW'(1);
                        end else begin
                            a_cnt_next = a_cnt_reg + AW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            m_cnt_reg     <= '0;
            a_cnt_reg     <= '0;
            row_reg       <= '0;
            ent_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_cnt_reg     <= m_cnt_next;
            a_cnt_reg     <= a_cnt_next;
            row_reg       <= row_next;
            ent_valid_reg <= ent_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_load) begin
            map_idx_reg   <= INDEX_OUT_W'(m_cnt_reg);
            angle_idx_reg <= INDEX_OUT_W'(a_cnt_reg);
            last_reg      <= is_last;
            for (int j = 0; j < NREPORT; j++) begin
                count_reg[j] <= row_counts[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    assign m_valid       = m_valid_reg;
    assign m_map_index   = map_idx_reg;
    assign m_angle_index = angle_idx_reg;
    assign m_bin_count_0 = count_reg[0];
    assign m_bin_count_1 = count_reg[1];
    assign m_bin_count_2 = count_reg[2];
    assign m_bin_count_3 = count_reg[3];
    assign m_bin_count_4 = count_reg[4];
    assign m_bin_count_5 = count_reg[5];
    assign m_last_row    = last_reg;

endmodule

### tb/sv/range_binned_histogram_tb.sv
// Self-checking testbench for range_binned_histogram: models the bin store and checks every readout row.
module range_binned_histogram_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbh_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int N_MAPS      = DEF_NUM_MAPS;
    localparam int N_ANG       = DEF_ANGLE_BINS;
    localparam int N_SEC       = DEF_SEC_BINS;
    localparam int N_CNT       = N_MAPS * N_ANG * N_SEC;
    localparam int CNT_CEIL    = DEF_MAX_RECORDS;
    localparam int DIST_MAX    = (1 << DIST_W) - 1;
    localparam int ANGLE_MAX   = (1 << ANGLE_W) - 1;
    localparam int IDLE_PCT    = 33;
    localparam int SETTLE      = 8;      // counter writes land in the cycle after accept
    localparam int END_WAIT    = 40;
    localparam int CYCLE_LIMIT = 200000;

    // index past the register map; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic               has_rec;
        logic [DIST_W-1:0]  pd;
        logic [DIST_W-1:0]  sd;
        logic [ANGLE_W-1:0] ang;
        logic               eos;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0]                  map_idx;
        logic [INDEX_OUT_W-1:0]                  ang_idx;
        logic [NREPORT-1:0][COUNT_OUT_W-1:0]     cnt;
        logic                                    last;
    } hist_row_t;

    // clock, reset, block ports
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_has_record = 1'b0;
    logic [DIST_W-1:0]      s_primary_dist = '0;
    logic [DIST_W-1:0]      s_secondary_dist = '0;
    logic [ANGLE_W-1:0]     s_bond_angle = '0;
    logic                   s_end_of_snapshot = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [INDEX_OUT_W-1:0] m_map_index;
    logic [INDEX_OUT_W-1:0] m_angle_index;
    logic [COUNT_OUT_W-1:0] m_bin_count_0;
    logic [COUNT_OUT_W-1:0] m_bin_count_1;
    logic [COUNT_OUT_W-1:0] m_bin_count_2;
    logic [COUNT_OUT_W-1:0] m_bin_count_3;
    logic [COUNT_OUT_W-1:0] m_bin_count_4;
    logic [COUNT_OUT_W-1:0] m_bin_count_5;
    logic                   m_last_row;

    // shadow of the register file and the bin store
    int pr_dist_base  = RST_DIST_BASE;
    int pr_dist_step  = RST_DIST_STEP;
    int pr_angle_base = RST_ANGLE_BASE;
    int pr_angle_step = RST_ANGLE_STEP;
    int pr_sec_base   = RST_SEC_BASE;
    int pr_sec_step   = RST_SEC_STEP;
    int hist_cnt [N_CNT] = '{default: 0};

    in_word_t  in_words [$];     // words waiting for the driver
    hist_row_t rows_due [$];     // readout rows predicted, not yet seen

    bit no_gaps = 1'b0;          // both sides run flat out while set
    int n_errors = 0;
    int words_sent = 0;
    int rows_checked = 0;
    int readouts = 0;
    int settings = 1;
    int cycle_count = 0;

    range_binned_histogram dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_has_record      (s_has_record),
        .s_primary_dist    (s_primary_dist),
        .s_secondary_dist  (s_secondary_dist),
        .s_bond_angle      (s_bond_angle),
        .s_end_of_snapshot (s_end_of_snapshot),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_map_index       (m_map_index),
        .m_angle_index     (m_angle_index),
        .m_bin_count_0     (m_bin_count_0),
        .m_bin_count_1     (m_bin_count_1),
        .m_bin_count_2     (m_bin_count_2),
        .m_bin_count_3     (m_bin_count_3),
        .m_bin_count_4     (m_bin_count_4),
        .m_bin_count_5     (m_bin_count_5),
        .m_last_row        (m_last_row)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------------------- prediction

    // One record: angle bin is the lowest closed range that holds it, secondary bin 0 is
    // closed and the rest open below, and every map whose closed range holds the primary
    // distance gets a count (shared edges count twice).
    function automatic void tally_record(int pd, int sd, int ang);
        int abin, sbin, lo, hi, idx;
        abin = -1;
        sbin = -1;
        for (int a = 0; a < N_ANG && abin < 0; a++) begin
            lo = pr_angle_base + a * pr_angle_step;
            hi = lo + pr_angle_step;
            if (ang >= lo && ang <= hi) abin = a;
        end
        if (abin < 0) return;
        for (int s = 0; s < N_SEC && sbin < 0; s++) begin
            lo = pr_sec_base + s * pr_sec_step;
            hi = lo + pr_sec_step;
            if (s == 0 ? (sd >= lo && sd <= hi) : (sd > lo && sd <= hi)) sbin = s;
        end
        if (sbin < 0) return;
        for (int m = 0; m < N_MAPS; m++) begin
            lo = pr_dist_base + m * pr_dist_step;
            hi = lo + pr_dist_step;
            idx = (m * N_ANG + abin) * N_SEC + sbin;
            if (pd >= lo && pd <= hi && hist_cnt[idx] < CNT_CEIL) hist_cnt[idx]++;
        end
    endfunction

    // End marker: one row per (map, angle bin), map-major, then the store is cleared.
    function automatic void emit_snapshot();
        int        n_rows, v;
        hist_row_t row;
        n_rows = (N_MAPS * N_ANG > ROWS_MAX) ? ROWS_MAX : N_MAPS * N_ANG;
        for (int r = 0; r < n_rows; r++) begin
            row.map_idx = INDEX_OUT_W'(r / N_ANG);
            row.ang_idx = INDEX_OUT_W'(r % N_ANG);
            for (int j = 0; j < NREPORT; j++) begin
                v = (j < N_SEC) ? hist_cnt[r * N_SEC + j] : 0;
                row.cnt[j] = COUNT_OUT_W'(v);
            end
            row.last = (r == n_rows - 1);
            rows_due.push_back(row);
        end
        hist_cnt = '{default: 0};
    endfunction

    // ---------------------------------------------------------------- input driver

    always @(posedge aclk) begin : drive_words
        in_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                words_sent++;
                if (s_has_record) begin
                    tally_record(int'(s_primary_dist), int'(s_secondary_dist),
                                 int'(s_bond_angle));
                end
                if (s_end_of_snapshot) emit_snapshot();
            end
            // a held word stays put; otherwise offer the next one or idle
            if (!s_valid || s_ready) begin
                if (in_words.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    w = in_words.pop_front();
                    s_valid           <= 1'b1;
                    s_has_record      <= w.has_rec;
                    s_primary_dist    <= w.pd;
                    s_secondary_dist  <= w.sd;
                    s_bond_angle      <= w.ang;
                    s_end_of_snapshot <= w.eos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor

    task automatic check_field(string name, logic [COUNT_OUT_W-1:0] want,
                               logic [COUNT_OUT_W-1:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch_rows
        hist_row_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rows_due.size() == 0) begin
                    n_errors++;
                    $display("%0t: row with nothing expected, map %0d angle %0d", $time,
                             m_map_index, m_angle_index);
                end else begin
                    want = rows_due.pop_front();
                    rows_checked++;
                    if (want.last) readouts++;
                    check_field("map_index", COUNT_OUT_W'(want.map_idx),
                                COUNT_OUT_W'(m_map_index));
                    check_field("angle_index", COUNT_OUT_W'(want.ang_idx),
                                COUNT_OUT_W'(m_angle_index));
                    check_field("bin_count_0", want.cnt[0], m_bin_count_0);
                    check_field("bin_count_1", want.cnt[1], m_bin_count_1);
                    check_field("bin_count_2", want.cnt[2], m_bin_count_2);
                    check_field("bin_count_3", want.cnt[3], m_bin_count_3);
                    check_field("bin_count_4", want.cnt[4], m_bin_count_4);
                    check_field("bin_count_5", want.cnt[5], m_bin_count_5);
                    check_field("last_row", COUNT_OUT_W'(want.last),
                                COUNT_OUT_W'(m_last_row));
                end
            end
            m_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still due", cycle_count,
                     rows_due.size());
            $display("range_binned_histogram_tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_word(bit has_rec, int pd, int sd, int ang, bit eos);
        in_word_t w;
        w.has_rec = has_rec;
        w.pd      = pd[DIST_W-1:0];
        w.sd      = sd[DIST_W-1:0];
        w.ang     = ang[ANGLE_W-1:0];
        w.eos     = eos;
        in_words.push_back(w);
    endtask

    // Register write; the shadow copy takes the masked value the block will keep.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_DIST_BASE:  pr_dist_base  = value & 16'hFFFF;
            REG_DIST_STEP:  pr_dist_step  = value & 16'h3FFF;
            REG_ANGLE_BASE: pr_angle_base = value & 16'h7FFF;
            REG_ANGLE_STEP: pr_angle_step = value & 16'h1FFF;
            REG_SEC_BASE:   pr_sec_base   = value & 16'hFFFF;
            REG_SEC_STEP:   pr_sec_step   = value & 16'h3FFF;
            default: ;
        endcase
    endtask

    task automatic set_all(int db, int ds, int ab, int as, int sb, int ss);
        write_reg(REG_DIST_BASE, db);
        write_reg(REG_DIST_STEP, ds);
        write_reg(REG_ANGLE_BASE, ab);
        write_reg(REG_ANGLE_STEP, as);
        write_reg(REG_SEC_BASE, sb);
        write_reg(REG_SEC_STEP, ss);
        write_reg(REG_NONE, $urandom_range(0, 16'hFFFF));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings++;
        @(negedge aclk);
    endtask

    // Mostly on or next to a bin edge, sometimes anywhere in the covered span,
    // sometimes anywhere in the field.
    function automatic int pick_near(int base, int step, int nbins, int maxv);
        int v;
        case ($urandom_range(0, 3))
            0, 1: v = base + int'($urandom_range(0, nbins)) * step
                      + int'($urandom_range(0, 2)) - 1;
            2: v = base + int'($urandom_range(0, nbins * step));
            default: v = int'($urandom_range(0, maxv));
        endcase
        if (v < 0) v = 0;
        if (v > maxv) v = maxv;
        return v;
    endfunction

    // n counted words; ignored fillers (no record, no marker) come on top
    task automatic queue_random(int n);
        int  done, kind;
        bit  eos;
        done = 0;
        while (done < n) begin
            kind = $urandom_range(0, 99);
            eos  = ($urandom_range(0, 99) < 6);
            if (kind < 10) begin
                push_word(1'b0, $urandom_range(0, DIST_MAX), $urandom_range(0, DIST_MAX),
                          $urandom_range(0, ANGLE_MAX), eos);
                if (eos) done++;
            end else if (kind < 20) begin
                push_word(1'b1, $urandom_range(0, DIST_MAX), $urandom_range(0, DIST_MAX),
                          $urandom_range(0, ANGLE_MAX), eos);
                done++;
            end else begin
                push_word(1'b1,
                          pick_near(pr_dist_base, pr_dist_step, N_MAPS, DIST_MAX),
                          pick_near(pr_sec_base, pr_sec_step, N_SEC, DIST_MAX),
                          pick_near(pr_angle_base, pr_angle_step, N_ANG, ANGLE_MAX), eos);
                done++;
            end
        end
        // close the phase with a bare marker so the store is read out and empty
        push_word(1'b0, $urandom_range(0, DIST_MAX), $urandom_range(0, DIST_MAX),
                  $urandom_range(0, ANGLE_MAX), 1'b1);
    endtask

    task automatic wait_drained(int settle);
        do @(negedge aclk); while (in_words.size() != 0 || s_valid || rows_due.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: maps 2300..2700 step 100, angle 15000..18000 step 1000,
        // secondary 500..2000 step 250.
        push_word(1'b0, 0, 0, 0, 1'b1);                         // empty store readout
        push_word(1'b0, DIST_MAX, DIST_MAX, ANGLE_MAX, 1'b0);   // ignored filler
        push_word(1'b1, 2300, 500, 15000, 1'b0);                // all lower edges
        push_word(1'b1, 2400, 750, 16000, 1'b0);                // map edge shared, angle low wins
        push_word(1'b1, 2700, 751, 18000, 1'b0);                // top edges, bin 1 open below
        push_word(1'b1, 2299, 600, 15500, 1'b0);                // below every map
        push_word(1'b1, 2701, 600, 15500, 1'b0);                // above every map
        push_word(1'b1, 2350, 600, 14999, 1'b0);                // angle too low
        push_word(1'b1, 2350, 600, 18001, 1'b0);                // angle too high
        push_word(1'b1, 2350, 499, 15500, 1'b0);                // secondary too low
        push_word(1'b1, 2350, 2001, 15500, 1'b0);               // secondary too high
        push_word(1'b1, 2550, 2000, 17500, 1'b0);               // top secondary bin
        push_word(1'b1, 0, 0, 0, 1'b0);
        push_word(1'b1, DIST_MAX, DIST_MAX, ANGLE_MAX, 1'b0);
        push_word(1'b1, 2500, 1000, 17000, 1'b1);               // record counted, then readout
        push_word(1'b0, DIST_MAX, 0, ANGLE_MAX, 1'b1);          // marker with stray fields
        repeat (4) push_word(1'b1, 2350, 600, 15500, 1'b0);     // same counter four times in a row
        push_word(1'b1, 2350, 1001, 15500, 1'b0);
        push_word(1'b0, 0, DIST_MAX, 0, 1'b1);
        queue_random(40);
        wait_drained(SETTLE);

        // Zero steps and bases: every range collapses onto zero. One unbroken stream
        // onto the four map counters of bin (0, 0).
        set_all(0, 0, 0, 0, 0, 0);
        no_gaps = 1'b1;
        repeat (40) push_word(1'b1, 0, 0, 0, 1'b0);
        push_word(1'b1, 0, 1, 0, 1'b1);
        wait_drained(SETTLE);
        no_gaps = 1'b0;
        queue_random(20);
        wait_drained(SETTLE);

        // Largest legal settings.
        set_all(DIST_MAX, 16383, 18000, 6000, DIST_MAX, 16383);
        push_word(1'b1, DIST_MAX, DIST_MAX, 24000, 1'b0);
        push_word(1'b1, DIST_MAX, DIST_MAX, ANGLE_MAX, 1'b0);
        queue_random(30);
        wait_drained(SETTLE);

        // Moderate random settings, then fully random ones.
        set_all($urandom_range(1000, 40000), $urandom_range(1, 2000),
                $urandom_range(0, 12000), $urandom_range(1, 2000),
                $urandom_range(0, 30000), $urandom_range(1, 3000));
        queue_random(40);
        wait_drained(SETTLE);

        set_all($urandom_range(0, DIST_MAX), $urandom_range(0, 16383),
                $urandom_range(0, 18000), $urandom_range(0, 6000),
                $urandom_range(0, DIST_MAX), $urandom_range(0, 16383));
        queue_random(40);
        wait_drained(END_WAIT);

        $display("covered %0d input words over %0d register settings", words_sent, settings);
        $display("checked %0d rows in %0d snapshot readouts, %0d mismatches", rows_checked,
                 readouts, n_errors);
        if (n_errors == 0) begin
            $display("range_binned_histogram_tb passed");
        end else begin
            $display("range_binned_histogram_tb failed");
        end
        $finish;
    end

endmodule
